/* design/rwb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwb_pkg: shared types for the reorder buffer with wakeup
// Request codes and the command group that runs between controller and
// datapath.
// ----------------------------------------------------------------------------
package rwb_pkg;

  // Request codes. Code 7 is unused and only reports status.
  typedef enum logic [2:0] {
    REQ_INSERT      = 3'd0,
    REQ_MARK_ISSUED = 3'd1,
    REQ_MARK_DONE   = 3'd2,
    REQ_WAKEUP      = 3'd3,
    REQ_REMOVE      = 3'd4,
    REQ_CHECK       = 3'd5,
    REQ_FLUSH       = 3'd6
  } rwb_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and read the head number
    logic exec;     // carry out the latched request
  } rwb_cmd_t;

endpackage : rwb_pkg
`default_nettype wire

/* design/rwb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwb_ctrl: request sequencer
// Steps each accepted request through execute and response cycles.
// ----------------------------------------------------------------------------
module rwb_ctrl
  import rwb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output rwb_cmd_t      cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // A new request may be taken while the previous result is shown.
  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.capture = accept;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign out_valid   = (state_r == ST_RESP);

endmodule : rwb_ctrl
`default_nettype wire

/* design/rwb_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwb_datapath: entry storage, pointers and result registers
// Flags and source fields sit in flip-flops for the parallel wakeup; the
// instruction numbers sit in a memory read at the head.
// ----------------------------------------------------------------------------
module rwb_datapath
  import rwb_pkg::*;
#(
  parameter int ROB_DEPTH = 32,
  parameter int NUM_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rwb_cmd_t          cmd,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [4:0]        in_tag,
  input  wire logic [31:0]       in_inst_num,
  input  wire logic signed [5:0] in_src1_tag,
  input  wire logic              in_src1_ready,
  input  wire logic signed [5:0] in_src2_tag,
  input  wire logic              in_src2_ready,
  output logic [4:0]             out_alloc_index,
  output logic                   out_insert_done,
  output logic                   out_tag_ready,
  output logic                   out_removed,
  output logic [31:0]            out_inst_num,
  output logic signed [5:0]      out_src1_tag,
  output logic                   out_src1_ready,
  output logic signed [5:0]      out_src2_tag,
  output logic                   out_src2_ready,
  output logic                   out_head_ready,
  output logic                   out_space_free
);

  localparam int PTR_W = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
  localparam int IDX_W = (PTR_W > 5) ? PTR_W : 5;
  localparam int NUM_X = (NUM_WIDTH > 32) ? NUM_WIDTH : 32;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ROB_DEPTH - 1);

  // Latched request.
  rwb_req_t       req_r;
  logic [4:0]     tag_r;
  logic [31:0]    num_in_r;
  logic [5:0]     s1_tag_in_r, s2_tag_in_r;
  logic           s1_rdy_in_r, s2_rdy_in_r;

  // Entry state.
  logic [ROB_DEPTH-1:0] valid_r, valid_nxt;
  logic [ROB_DEPTH-1:0] issued_r, issued_nxt;
  logic [ROB_DEPTH-1:0] done_r, done_nxt;
  logic [ROB_DEPTH-1:0] live_r, live_nxt;   // number written and not retired
  logic [5:0]           s1_tag_r [ROB_DEPTH];
  logic [5:0]           s2_tag_r [ROB_DEPTH];
  logic [ROB_DEPTH-1:0] s1_rdy_r, s1_rdy_nxt;
  logic [ROB_DEPTH-1:0] s2_rdy_r, s2_rdy_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt, tail_r, tail_nxt;

  logic [NUM_WIDTH-1:0] num_mem [ROB_DEPTH];
  logic [NUM_WIDTH-1:0] rd_num_r;
  logic                 rd_live_r;

  // Results.
  logic [4:0]  alloc_r, alloc_nxt;
  logic        ins_r, ins_nxt, trdy_r, trdy_nxt, rem_r, rem_nxt;
  logic [31:0] onum_r, onum_nxt;
  logic [5:0]  os1_tag_r, os1_tag_nxt, os2_tag_r, os2_tag_nxt;
  logic        os1_rdy_r, os1_rdy_nxt, os2_rdy_r, os2_rdy_nxt;

  logic [IDX_W-1:0] tag_ext, tail_ext;
  logic [PTR_W-1:0] tag_idx;
  logic             tag_ok, space, wr_insert;
  logic [NUM_X-1:0] num_wr_ext, num_rd_ext;
  logic [5:0]       wake_tag;

  assign tag_ext    = IDX_W'(tag_r);
  assign tag_idx    = tag_ext[PTR_W-1:0];
  assign tag_ok     = ({27'd0, tag_r} < 32'(ROB_DEPTH));
  assign tail_ext   = IDX_W'(tail_r);
  assign space      = (head_r != tail_r) || !valid_r[tail_r];
  assign wr_insert  = cmd.exec && (req_r == REQ_INSERT) && space;
  assign num_wr_ext = NUM_X'(num_in_r);
  assign num_rd_ext = NUM_X'(rd_num_r);
  assign wake_tag   = {1'b0, tag_r};   // a source tag of -1 never matches

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r       <= rwb_req_t'(in_req_type);
      tag_r       <= in_tag;
      num_in_r    <= in_inst_num;
      s1_tag_in_r <= in_src1_tag;
      s1_rdy_in_r <= in_src1_ready;
      s2_tag_in_r <= in_src2_tag;
      s2_rdy_in_r <= in_src2_ready;
      rd_num_r    <= num_mem[head_r];
      rd_live_r   <= live_r[head_r];
    end
    if (wr_insert) begin
      num_mem[tail_r]  <= num_wr_ext[NUM_WIDTH-1:0];
      s1_tag_r[tail_r] <= s1_tag_in_r;
      s2_tag_r[tail_r] <= s2_tag_in_r;
    end
  end

  always_comb begin
    valid_nxt   = valid_r;
    issued_nxt  = issued_r;
    done_nxt    = done_r;
    live_nxt    = live_r;
    s1_rdy_nxt  = s1_rdy_r;
    s2_rdy_nxt  = s2_rdy_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    alloc_nxt   = '0;
    ins_nxt     = 1'b0;
    trdy_nxt    = 1'b0;
    rem_nxt     = 1'b0;
    onum_nxt    = '0;
    os1_tag_nxt = '0;
    os1_rdy_nxt = 1'b0;
    os2_tag_nxt = '0;
    os2_rdy_nxt = 1'b0;
    unique case (req_r)
      REQ_INSERT: begin
        alloc_nxt = tail_ext[4:0];
        if (space) begin
          ins_nxt            = 1'b1;
          valid_nxt[tail_r]  = 1'b1;
          live_nxt[tail_r]   = 1'b1;
          s1_rdy_nxt[tail_r] = s1_rdy_in_r;
          s2_rdy_nxt[tail_r] = s2_rdy_in_r;
          tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
        end
      end
      REQ_MARK_ISSUED: begin
        if (tag_ok && valid_r[tag_idx] && !issued_r[tag_idx]) issued_nxt[tag_idx] = 1'b1;
      end
      REQ_MARK_DONE: begin
        if (tag_ok && valid_r[tag_idx] && issued_r[tag_idx]) done_nxt[tag_idx] = 1'b1;
      end
      REQ_WAKEUP: begin
        for (int i = 0; i < ROB_DEPTH; i++) begin
          if (valid_r[i] && (s1_tag_r[i] == wake_tag)) s1_rdy_nxt[i] = 1'b1;
          if (valid_r[i] && (s2_tag_r[i] == wake_tag)) s2_rdy_nxt[i] = 1'b1;
        end
      end
      REQ_REMOVE: begin
        onum_nxt    = rd_live_r ? num_rd_ext[31:0] : 32'd0;
        os1_tag_nxt = s1_tag_r[head_r];
        os1_rdy_nxt = s1_rdy_r[head_r];
        os2_tag_nxt = s2_tag_r[head_r];
        os2_rdy_nxt = s2_rdy_r[head_r];
        if (valid_r[head_r] && done_r[head_r]) begin
          rem_nxt            = 1'b1;
          valid_nxt[head_r]  = 1'b0;
          issued_nxt[head_r] = 1'b0;
          done_nxt[head_r]   = 1'b0;
          live_nxt[head_r]   = 1'b0;
          head_nxt = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
        end
      end
      REQ_CHECK: begin
        trdy_nxt = tag_ok && valid_r[tag_idx] && done_r[tag_idx];
      end
      REQ_FLUSH: begin
        valid_nxt  = '0;
        issued_nxt = '0;
        done_nxt   = '0;
        head_nxt   = '0;
        tail_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      issued_r <= '0;
      done_r   <= '0;
      live_r   <= '0;
      head_r   <= '0;
      tail_r   <= '0;
    end else if (cmd.exec) begin
      valid_r  <= valid_nxt;
      issued_r <= issued_nxt;
      done_r   <= done_nxt;
      live_r   <= live_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      s1_rdy_r  <= s1_rdy_nxt;
      s2_rdy_r  <= s2_rdy_nxt;
      alloc_r   <= alloc_nxt;
      ins_r     <= ins_nxt;
      trdy_r    <= trdy_nxt;
      rem_r     <= rem_nxt;
      onum_r    <= onum_nxt;
      os1_tag_r <= os1_tag_nxt;
      os1_rdy_r <= os1_rdy_nxt;
      os2_tag_r <= os2_tag_nxt;
      os2_rdy_r <= os2_rdy_nxt;
    end
  end

  assign out_alloc_index = alloc_r;
  assign out_insert_done = ins_r;
  assign out_tag_ready   = trdy_r;
  assign out_removed     = rem_r;
  assign out_inst_num    = onum_r;
  assign out_src1_tag    = os1_tag_r;
  assign out_src1_ready  = os1_rdy_r;
  assign out_src2_tag    = os2_tag_r;
  assign out_src2_ready  = os2_rdy_r;
  // Status is read from the updated state while the result is shown.
  assign out_head_ready  = valid_r[head_r] && done_r[head_r];
  assign out_space_free  = space;

endmodule : rwb_datapath
`default_nettype wire

/* design/reorder_buffer_with_wakeup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// reorder_buffer_with_wakeup: circular reorder buffer with source wakeup
// One request per item: insert, mark issued, mark done, wakeup, remove
// head, check ready or flush; each request gives exactly one result.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge where start is high and busy is
// low. The request is executed in the following cycle, during which busy is
// high. In the cycle after that the result appears on the out_ ports with
// out_valid high for exactly that one cycle; the receiver cannot stall it and
// must take it then. Since busy is already low while the result is shown, a
// new request can be taken in that same cycle; each request still passes
// through the single execute step that updates the entry flags, after the
// registered read of the instruction number memory. Fields that do not
// belong to a request read as zero. Head-ready and free-space status always
// describe the buffer after the request. Reset (synchronous, rst_n low)
// clears the valid, issued, done and live flags and both pointers at once;
// no clearing pass is needed, so a request may follow straight away.
// ----------------------------------------------------------------------------
module reorder_buffer_with_wakeup
  import rwb_pkg::*;
#(
  parameter int ROB_DEPTH = 32,
  parameter int NUM_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [4:0]        in_tag,
  input  wire logic [31:0]       in_inst_num,
  input  wire logic signed [5:0] in_src1_tag,
  input  wire logic              in_src1_ready,
  input  wire logic signed [5:0] in_src2_tag,
  input  wire logic              in_src2_ready,
  output logic                   out_valid,
  output logic [4:0]             out_alloc_index,
  output logic                   out_insert_done,
  output logic                   out_tag_ready,
  output logic                   out_removed,
  output logic [31:0]            out_inst_num,
  output logic signed [5:0]      out_src1_tag,
  output logic                   out_src1_ready,
  output logic signed [5:0]      out_src2_tag,
  output logic                   out_src2_ready,
  output logic                   out_head_ready,
  output logic                   out_space_free
);

  rwb_cmd_t cmd;

  // The controller sequences each request; the datapath holds the entries.
  rwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rwb_datapath #(
    .ROB_DEPTH (ROB_DEPTH),
    .NUM_WIDTH (NUM_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_tag          (in_tag),
    .in_inst_num     (in_inst_num),
    .in_src1_tag     (in_src1_tag),
    .in_src1_ready   (in_src1_ready),
    .in_src2_tag     (in_src2_tag),
    .in_src2_ready   (in_src2_ready),
    .out_alloc_index (out_alloc_index),
    .out_insert_done (out_insert_done),
    .out_tag_ready   (out_tag_ready),
    .out_removed     (out_removed),
    .out_inst_num    (out_inst_num),
    .out_src1_tag    (out_src1_tag),
    .out_src1_ready  (out_src1_ready),
    .out_src2_tag    (out_src2_tag),
    .out_src2_ready  (out_src2_ready),
    .out_head_ready  (out_head_ready),
    .out_space_free  (out_space_free)
  );

  // A taken request always leads to the execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("taken request did not enter execution");

  // Every execute cycle is followed by exactly one result strobe.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execution not followed by a result");

  // A result is only shown after an execute cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding execution");

endmodule : reorder_buffer_with_wakeup
`default_nettype wire

/* bench/rob_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_result_checker: result predictor and comparator for the reorder buffer
// Watches the request and result channels. It keeps its own copy of the entry
// flags, the stored fields and both pointers, and works out the result of
// every accepted request. Each result is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rob_result_checker
  import rwb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [4:0]  tag,
  input  wire logic [31:0] req_num,
  input  wire logic [5:0]  req_s1_tag,
  input  wire logic        req_s1_rdy,
  input  wire logic [5:0]  req_s2_tag,
  input  wire logic        req_s2_rdy,
  input  wire logic        out_valid,
  input  wire logic [4:0]  out_alloc_index,
  input  wire logic        out_insert_done,
  input  wire logic        out_tag_ready,
  input  wire logic        out_removed,
  input  wire logic [31:0] out_inst_num,
  input  wire logic [5:0]  out_src1_tag,
  input  wire logic        out_src1_ready,
  input  wire logic [5:0]  out_src2_tag,
  input  wire logic        out_src2_ready,
  input  wire logic        out_head_ready,
  input  wire logic        out_space_free,
  input  wire logic        drain_check,
  output int               fail_count
);

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [4:0]  alloc_index;
    logic        insert_done;
    logic        tag_ready;
    logic        removed;
    logic [31:0] num;
    logic [5:0]  s1_tag;
    logic        s1_rdy;
    logic [5:0]  s2_tag;
    logic        s2_rdy;
    logic        head_ready;
    logic        space_free;
  } rob_result_t;

  logic        ent_valid  [DEPTH];
  logic        ent_issued [DEPTH];
  logic        ent_done   [DEPTH];
  logic [31:0] ent_num    [DEPTH];
  logic [5:0]  ent_s1_tag [DEPTH];
  logic        ent_s1_rdy [DEPTH];
  logic [5:0]  ent_s2_tag [DEPTH];
  logic        ent_s2_rdy [DEPTH];
  logic [4:0]  head_idx;
  logic [4:0]  tail_idx;

  rob_result_t pending_results [$];
  logic        leftover_done;

  initial fail_count = 0;
  initial leftover_done = 1'b0;

  function automatic logic rob_has_space();
    return (head_idx != tail_idx) || !ent_valid[tail_idx];
  endfunction

  // Applies one request to the model and returns the result it gives.
  function automatic rob_result_t rob_execute(input logic [2:0] req, input logic [4:0] t,
                                              input logic [31:0] num, input logic [5:0] s1,
                                              input logic r1, input logic [5:0] s2,
                                              input logic r2);
    rob_result_t res;
    int i;
    res = '0;
    case (req)
      REQ_INSERT: begin
        res.alloc_index = tail_idx;
        if (rob_has_space()) begin
          ent_num[tail_idx]    = num;
          ent_s1_tag[tail_idx] = s1;
          ent_s1_rdy[tail_idx] = r1;
          ent_s2_tag[tail_idx] = s2;
          ent_s2_rdy[tail_idx] = r2;
          ent_valid[tail_idx]  = 1'b1;
          tail_idx             = tail_idx + 5'd1;
          res.insert_done      = 1'b1;
        end
      end
      REQ_MARK_ISSUED: begin
        if (ent_valid[t] && !ent_issued[t]) ent_issued[t] = 1'b1;
      end
      REQ_MARK_DONE: begin
        if (ent_valid[t] && ent_issued[t]) ent_done[t] = 1'b1;
      end
      REQ_WAKEUP: begin
        // A source with no producer holds all ones and so never matches.
        for (i = 0; i < DEPTH; i++) begin
          if (ent_valid[i]) begin
            if (ent_s1_tag[i] == {1'b0, t}) ent_s1_rdy[i] = 1'b1;
            if (ent_s2_tag[i] == {1'b0, t}) ent_s2_rdy[i] = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        res.num    = ent_num[head_idx];
        res.s1_tag = ent_s1_tag[head_idx];
        res.s1_rdy = ent_s1_rdy[head_idx];
        res.s2_tag = ent_s2_tag[head_idx];
        res.s2_rdy = ent_s2_rdy[head_idx];
        if (ent_valid[head_idx] && ent_done[head_idx]) begin
          ent_valid[head_idx]  = 1'b0;
          ent_issued[head_idx] = 1'b0;
          ent_done[head_idx]   = 1'b0;
          ent_num[head_idx]    = '0;
          head_idx             = head_idx + 5'd1;
          res.removed          = 1'b1;
        end
      end
      REQ_CHECK: begin
        res.tag_ready = ent_valid[t] && ent_done[t];
      end
      REQ_FLUSH: begin
        // Stored fields survive a flush; only the flags and pointers clear.
        for (i = 0; i < DEPTH; i++) begin
          ent_valid[i]  = 1'b0;
          ent_issued[i] = 1'b0;
          ent_done[i]   = 1'b0;
        end
        head_idx = '0;
        tail_idx = '0;
      end
      default: begin
      end
    endcase
    res.head_ready = ent_valid[head_idx] && ent_done[head_idx];
    res.space_free = rob_has_space();
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rob_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_valid[i]  = 1'b0;
        ent_issued[i] = 1'b0;
        ent_done[i]   = 1'b0;
        ent_num[i]    = '0;
        ent_s1_tag[i] = '0;
        ent_s1_rdy[i] = 1'b0;
        ent_s2_tag[i] = '0;
        ent_s2_rdy[i] = 1'b0;
      end
      head_idx = '0;
      tail_idx = '0;
      pending_results.delete();
    end else begin
      // The result shown now belongs to an earlier request, so compare first.
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("alloc_index", 32'(want.alloc_index), 32'(out_alloc_index));
          check_field("insert_done", 32'(want.insert_done), 32'(out_insert_done));
          check_field("tag_ready", 32'(want.tag_ready), 32'(out_tag_ready));
          check_field("removed", 32'(want.removed), 32'(out_removed));
          check_field("num", want.num, out_inst_num);
          check_field("s1_tag", {26'd0, want.s1_tag}, {26'd0, out_src1_tag});
          check_field("s1_rdy", 32'(want.s1_rdy), 32'(out_src1_ready));
          check_field("s2_tag", {26'd0, want.s2_tag}, {26'd0, out_src2_tag});
          check_field("s2_rdy", 32'(want.s2_rdy), 32'(out_src2_ready));
          check_field("head_ready", 32'(want.head_ready), 32'(out_head_ready));
          check_field("space_free", 32'(want.space_free), 32'(out_space_free));
        end
      end
      if (start && !busy) begin
        pending_results.push_back(rob_execute(req_type, tag, req_num, req_s1_tag, req_s1_rdy,
                                              req_s2_tag, req_s2_rdy));
      end
      if (drain_check && !leftover_done) begin
        leftover_done = 1'b1;
        if (pending_results.size() != 0) begin
          $display("%0t: %0d results never arrived", $time, pending_results.size());
          fail_count++;
        end
      end
    end
  end

endmodule : rob_result_checker

/* bench/tb_reorder_buffer_with_wakeup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reorder_buffer_with_wakeup: request-level test of the reorder buffer
// Drives a directed opening and then a long stream of random requests shaped
// around instruction life cycles, with random gaps between requests. The
// checker beside the block predicts and compares every result; this module
// only makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_reorder_buffer_with_wakeup;
  import rwb_pkg::*;

  // The block has eight request codes but defines only seven; the last one
  // must leave the state alone and report status only.
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam int RANDOM_REQUESTS = 1250;
  // This covers the time from a request to its result with margin.
  localparam int SETTLE_CYCLES   = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_req_type = '0;
  logic [4:0]        in_tag = '0;
  logic [31:0]       in_inst_num = '0;
  logic signed [5:0] in_src1_tag = '0;
  logic              in_src1_ready = 1'b0;
  logic signed [5:0] in_src2_tag = '0;
  logic              in_src2_ready = 1'b0;
  logic              out_valid;
  logic [4:0]        out_alloc_index;
  logic              out_insert_done;
  logic              out_tag_ready;
  logic              out_removed;
  logic [31:0]       out_inst_num;
  logic signed [5:0] out_src1_tag;
  logic              out_src1_ready;
  logic signed [5:0] out_src2_tag;
  logic              out_src2_ready;
  logic              out_head_ready;
  logic              out_space_free;
  logic              drain_check = 1'b0;
  int                fail_count;

  // Bookkeeping for the stimulus. The number of requests taken is kept by the
  // sender; the number of results seen and of entries retired is kept by the
  // observer below, so each counter has exactly one writer.
  int         requests_taken = 0;
  int         results_seen = 0;
  int         retired_total = 0;
  int         retired_at_flush = 0;
  logic       burst = 1'b0;
  logic [4:0] head_guess;

  always #1 clk = ~clk;

  reorder_buffer_with_wakeup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_tag         (in_tag),
    .in_inst_num    (in_inst_num),
    .in_src1_tag    (in_src1_tag),
    .in_src1_ready  (in_src1_ready),
    .in_src2_tag    (in_src2_tag),
    .in_src2_ready  (in_src2_ready),
    .out_valid      (out_valid),
    .out_alloc_index(out_alloc_index),
    .out_insert_done(out_insert_done),
    .out_tag_ready  (out_tag_ready),
    .out_removed    (out_removed),
    .out_inst_num   (out_inst_num),
    .out_src1_tag   (out_src1_tag),
    .out_src1_ready (out_src1_ready),
    .out_src2_tag   (out_src2_tag),
    .out_src2_ready (out_src2_ready),
    .out_head_ready (out_head_ready),
    .out_space_free (out_space_free)
  );

  rob_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (in_req_type),
    .tag            (in_tag),
    .req_num        (in_inst_num),
    .req_s1_tag     (in_src1_tag),
    .req_s1_rdy     (in_src1_ready),
    .req_s2_tag     (in_src2_tag),
    .req_s2_rdy     (in_src2_ready),
    .out_valid      (out_valid),
    .out_alloc_index(out_alloc_index),
    .out_insert_done(out_insert_done),
    .out_tag_ready  (out_tag_ready),
    .out_removed    (out_removed),
    .out_inst_num   (out_inst_num),
    .out_src1_tag   (out_src1_tag),
    .out_src1_ready (out_src1_ready),
    .out_src2_tag   (out_src2_tag),
    .out_src2_ready (out_src2_ready),
    .out_head_ready (out_head_ready),
    .out_space_free (out_space_free),
    .drain_check    (drain_check),
    .fail_count     (fail_count)
  );

  // The observer counts results and retirements with nonblocking updates, so
  // the sender always reads the values from before the current edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen <= results_seen + 1;
      if (out_removed === 1'b1) retired_total <= retired_total + 1;
    end
  end

  // The head of the buffer, as far as the sender can tell from the results.
  // It may lag by a request or so, which only blurs the aim of the marks.
  assign head_guess = 5'(retired_total - retired_at_flush);

  // Gap before a request: none during a burst, otherwise none half the time
  // and a random idle gap the rest.
  function automatic int draw_gap();
    if (burst || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // A source tag for an insert: often no producer at all, otherwise any entry.
  function automatic logic [5:0] draw_src();
    if ($urandom_range(0, 3) == 0) return 6'h3f;
    return 6'($urandom_range(0, 31));
  endfunction

  // An entry to mark or check. Most aim at the head or just behind it, so that
  // the oldest instructions complete and the head can retire.
  function automatic logic [4:0] pick_slot();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return 5'(head_guess + $urandom_range(0, 3));
    if (p < 9) return 5'(head_guess + $urandom_range(0, 15));
    return 5'($urandom_range(0, 31));
  endfunction

  // Presents one request after a random gap and holds it until it is taken.
  // Start stays high when the next request follows at once, so it is never
  // lowered and raised within one time step.
  task automatic issue_request(input logic [2:0] req, input logic [4:0] tag,
                               input logic [31:0] num, input logic [5:0] s1,
                               input logic r1, input logic [5:0] s2, input logic r2);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_tag        <= tag;
    in_inst_num   <= num;
    in_src1_tag   <= s1;
    in_src1_ready <= r1;
    in_src2_tag   <= s2;
    in_src2_ready <= r2;
    do @(posedge clk); while (busy);
    requests_taken++;
  endtask

  // A request whose payload does not matter gets random content anyway.
  task automatic issue_simple(input logic [2:0] req, input logic [4:0] tag);
    issue_request(req, tag, $urandom, 6'($urandom), 1'($urandom), 6'($urandom),
                  1'($urandom));
  endtask

  // Holds the sender off until every request taken has given its result. A
  // quiet buffer already has start low, so nothing is driven then.
  task automatic wait_drained();
    if (results_seen != requests_taken) begin
      start <= 1'b0;
      while (results_seen != requests_taken) @(posedge clk);
    end
  endtask

  // A flush is sent into a quiet buffer, so the head estimate can restart at
  // zero without a retirement still in flight.
  task automatic flush_buffer();
    wait_drained();
    issue_simple(REQ_FLUSH, 5'($urandom));
    wait_drained();
    retired_at_flush = retired_total;
  endtask

  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Requests on the empty buffer first: a wakeup with
    // nothing to wake, a check of an invalid entry, the unused code and a mark
    // of an entry that does not exist.
    issue_simple(REQ_WAKEUP, 5'd31);
    issue_simple(REQ_CHECK, 5'd0);
    issue_simple(REQ_UNUSED, 5'd0);
    issue_simple(REQ_MARK_ISSUED, 5'd3);

    // Fill every entry, with the number and source extremes spread across
    // them, then try one more insert into the full buffer. Filling also means
    // that every entry holds written source fields before any head removal.
    for (int i = 0; i < 32; i++) begin
      issue_request(REQ_INSERT, 5'($urandom),
                    (i == 0) ? 32'd0 : (i == 1) ? 32'hffff_ffff : $urandom,
                    (i % 3 == 0) ? 6'h3f : 6'(i), 1'(i),
                    (i % 4 == 1) ? 6'h3f : 6'(31 - i), 1'(i >> 1));
    end
    issue_request(REQ_INSERT, 5'd0, 32'h1234_5678, 6'd5, 1'b0, 6'd6, 1'b0);

    // Marks out of order, a removal that is not ready, then one instruction
    // taken through its whole life, woken sources and a retirement.
    issue_simple(REQ_MARK_DONE, 5'd0);
    issue_simple(REQ_REMOVE, 5'd0);
    issue_simple(REQ_MARK_ISSUED, 5'd0);
    issue_simple(REQ_MARK_ISSUED, 5'd0);
    issue_simple(REQ_MARK_DONE, 5'd0);
    issue_simple(REQ_CHECK, 5'd0);
    issue_simple(REQ_WAKEUP, 5'd31);
    issue_simple(REQ_WAKEUP, 5'd0);
    issue_simple(REQ_REMOVE, 5'd0);
    // The tail has wrapped to the freed entry, so this insert succeeds.
    issue_request(REQ_INSERT, 5'd0, 32'hdead_beef, 6'h3f, 1'b1, 6'd31, 1'b1);

    // A removal and a check on a flushed buffer.
    flush_buffer();
    issue_simple(REQ_REMOVE, 5'd0);
    issue_simple(REQ_CHECK, 5'd31);
    wait_drained();

    // Random part. Most requests follow instruction life cycles: inserts,
    // marks aimed near the head, wakeups and removals; the rest is checks,
    // the unused code and the odd flush. Bursts without gaps come and go.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 125 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 28) begin
        issue_request(REQ_INSERT, 5'($urandom), $urandom, draw_src(), 1'($urandom),
                      draw_src(), 1'($urandom));
      end else if (r < 45) begin
        issue_simple(REQ_MARK_ISSUED, pick_slot());
      end else if (r < 62) begin
        issue_simple(REQ_MARK_DONE, pick_slot());
      end else if (r < 72) begin
        issue_simple(REQ_WAKEUP, 5'($urandom));
      end else if (r < 86) begin
        issue_simple(REQ_REMOVE, 5'($urandom));
      end else if (r < 95) begin
        issue_simple(REQ_CHECK, pick_slot());
      end else if (r < 97) begin
        issue_simple(REQ_UNUSED, 5'($urandom));
      end else begin
        flush_buffer();
      end
    end

    // Let every outstanding result arrive, wait the settle time for any stray
    // strobe, and have the checker account for what is left.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule : tb_reorder_buffer_with_wakeup
